FILE: hdl/soa_pkg.sv
// Shared types, constants and helper functions for the slab object allocator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package soa_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int MODE_W = 2;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 16;
  localparam int ST_W   = 2;
  localparam int PIU_W  = 5;

  // Size classes.
  localparam int NUM_CLASSES = 18;
  localparam int CLS_W       = 5;
  localparam int CLASS_W     = 12;

  // Width of the shared add/compare unit; holds any offset up to 64 KiB plus one object.
  localparam int ALU_W = 17;

  // Default geometry of the pool.
  localparam int NUM_PAGES_DEF    = 16;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 24;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC_OBJ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE_OBJ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC_PG  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FREE_PG   = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_CLASS = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_PAGE  = 2'd2;

  // Object size of each class in bytes.
  localparam logic [CLASS_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    12'd2, 12'd4, 12'd8, 12'd12, 12'd16, 12'd24, 12'd32, 12'd40, 12'd48,
    12'd56, 12'd64, 12'd96, 12'd128, 12'd192, 12'd256, 12'd512, 12'd1024, 12'd2048
  };

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address_out;
    logic [ST_W-1:0]   status;
    logic [PIU_W-1:0]  pages_in_use;
  } out_item_t;

  // Request to and response from the shared add/compare unit.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             sum_le;
    logic             a_ge;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_CLASS,
    S_FPOP,
    S_SEEK,
    S_THREAD,
    S_REC_WAIT,
    S_OBJ_RD,
    S_OBJ_UPD,
    S_FULL_B,
    S_FULL_C,
    S_FULL_D,
    S_FREE_UPD,
    S_FREE_B,
    S_FREE_C,
    S_FREE_D,
    S_FX_RD,
    S_FX_WR,
    S_DONE
  } state_t;

  // Smallest class that holds the size; NUM_CLASSES when none does.
  function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] sz);
    logic [CLS_W-1:0] c;
    c = CLS_W'(NUM_CLASSES);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({4'd0, CLASS_BYTES[i]} >= sz) begin
        c = CLS_W'(i);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/slab_object_allocator_top.sv
// Top level of the slab object allocator: sequencer, page tables and free page stack.
// Depends on soa_pkg, soa_alu and soa_link_mem.
`default_nettype none

//  Channel | Direction | Ports                          | Payload
//  input   | in        | in_valid, in_stall, in_data    | in_item_t (mode, size, address)
//  result  | out       | out_valid, out_stall, out_data | out_item_t (address_out, status,
//          |           |                                |   pages_in_use)
//
// One item is taken at a time; the input stalls until its result is in the output register.
// A fresh slab page first steps by the object size up to the header and then threads each
// object, all through the one add/compare unit and the link memory write port.
// Reset is synchronous and active low; it empties all lists and refills the page stack.
// A waiting result does not block the next transfer in; only loading the next result waits.
// PAGE_BYTES must be a power of two.

module slab_object_allocator_top #(
  parameter int NUM_PAGES    = soa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES   = soa_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = soa_pkg::HEADER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  soa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output soa_pkg::out_item_t out_data
);
  import soa_pkg::*;

  localparam int PB_W       = $clog2(PAGE_BYTES);
  localparam int PG_W       = $clog2(NUM_PAGES + 1);
  localparam int PGI_W      = $clog2(NUM_PAGES);
  localparam int LINK_AW    = PGI_W + PB_W - 1;
  localparam int LINK_DEPTH = NUM_PAGES * PAGE_BYTES / 2;
  localparam logic [PG_W-1:0] NO_PAGE = PG_W'(NUM_PAGES);

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [PB_W-1:0]  foff;
    logic [PG_W-1:0]  prev;
    logic [PG_W-1:0]  next;
  } rec_t;

  // Sequencer registers.
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [CLASS_W-1:0] obj_r, obj_nxt;
  logic [ALU_W-1:0]  lim_r, lim_nxt;
  logic [ALU_W-1:0]  off_r, off_nxt;
  logic [PG_W-1:0]   pg_r, pg_nxt;
  rec_t              rec_r, rec_nxt;
  logic [PG_W-1:0]   nb_p_r, nb_p_nxt, nb_n_r, nb_n_nxt, hd_r, hd_nxt;
  logic [PG_W-1:0]   fix_tgt_r, fix_tgt_nxt, fix_val_r, fix_val_nxt;
  logic              fix_next_r, fix_next_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;

  // Free page stack and list heads.
  logic [PG_W-1:0] top_r, top_nxt, count_r, count_nxt;
  logic [PG_W-1:0] partial_head_r [NUM_CLASSES];
  logic [PG_W-1:0] partial_head_nxt [NUM_CLASSES];
  logic [PG_W-1:0] full_head_r [NUM_CLASSES];
  logic [PG_W-1:0] full_head_nxt [NUM_CLASSES];

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Page record memory.
  rec_t             rec_mem [NUM_PAGES];
  rec_t             rec_q_r;
  logic [PGI_W-1:0] rec_ra, rec_wa;
  logic             rec_we;
  rec_t             rec_wd, rec_fix;

  // Free page link memory; an entry never written reads as its index plus one.
  logic [PG_W-1:0]  flink_mem [NUM_PAGES];
  logic             flink_vld_r [NUM_PAGES];
  logic [PG_W-1:0]  flink_q_r;
  logic             flink_vld_q_r;
  logic [PGI_W-1:0] flink_idx_q_r;
  logic [PGI_W-1:0] flink_ra, flink_wa;
  logic             flink_we;
  logic [PG_W-1:0]  flink_wd, flink_val;

  // Object link memory ports.
  logic               link_we;
  logic [LINK_AW-1:0] link_wa, link_ra;
  logic [PB_W-1:0]    link_wd, link_rd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Decoded helpers.
  logic [ALU_W-1:0]  addr_pg_w;
  logic              addr_pg_ok;
  logic [PG_W-1:0]   addr_pg;
  logic [PB_W-1:0]   addr_off;
  logic              page_avail;
  logic [CLS_W-1:0]  rq_cls;
  logic [31:0]       obj_full, pg_base, piu_full;
  logic              in_xfer;

  soa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  soa_link_mem #(
    .DEPTH (LINK_DEPTH),
    .AW    (LINK_AW),
    .DW    (PB_W)
  ) u_link_mem (
    .clk (clk),
    .we  (link_we),
    .wa  (link_wa),
    .wd  (link_wd),
    .ra  (link_ra),
    .rd  (link_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Page and offset of the request address.
  assign addr_pg_w  = ALU_W'(addr_r) >> PB_W;
  assign addr_pg_ok = addr_pg_w < ALU_W'(NUM_PAGES);
  assign addr_pg    = addr_pg_w[PG_W-1:0];
  assign addr_off   = addr_r[PB_W-1:0];
  assign page_avail = (count_r != '0) && (top_r < NO_PAGE);

  // A class read from a record that is out of range falls back to the first class.
  assign rq_cls    = (rec_q_r.cls >= CLS_W'(NUM_CLASSES)) ? '0 : rec_q_r.cls;
  assign flink_val = flink_vld_q_r ? flink_q_r : PG_W'(flink_idx_q_r) + PG_W'(1);
  assign obj_full  = (32'(pg_r) << PB_W) | 32'(off_r);
  assign pg_base   = 32'(top_r) << PB_W;
  assign piu_full  = 32'(NUM_PAGES) - 32'(count_r);

  // Record with one link field replaced, for a single neighbor update.
  always_comb begin
    rec_fix = rec_q_r;
    if (fix_next_r) begin
      rec_fix.next = fix_val_r;
    end else begin
      rec_fix.prev = fix_val_r;
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt        = state_r;
    ret_nxt          = ret_r;
    mode_nxt         = mode_r;
    size_nxt         = size_r;
    addr_nxt         = addr_r;
    cls_nxt          = cls_r;
    obj_nxt          = obj_r;
    lim_nxt          = lim_r;
    off_nxt          = off_r;
    pg_nxt           = pg_r;
    rec_nxt          = rec_r;
    nb_p_nxt         = nb_p_r;
    nb_n_nxt         = nb_n_r;
    hd_nxt           = hd_r;
    fix_tgt_nxt      = fix_tgt_r;
    fix_val_nxt      = fix_val_r;
    fix_next_nxt     = fix_next_r;
    res_addr_nxt     = res_addr_r;
    res_st_nxt       = res_st_r;
    top_nxt          = top_r;
    count_nxt        = count_r;
    partial_head_nxt = partial_head_r;
    full_head_nxt    = full_head_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    rec_ra   = pg_r[PGI_W-1:0];
    rec_we   = 1'b0;
    rec_wa   = pg_r[PGI_W-1:0];
    rec_wd   = rec_r;
    flink_ra = top_r[PGI_W-1:0];
    flink_we = 1'b0;
    flink_wa = addr_pg[PGI_W-1:0];
    flink_wd = top_r;
    link_we  = 1'b0;
    link_wa  = {pg_r[PGI_W-1:0], off_r[PB_W-1:1]};
    link_wd  = '0;
    link_ra  = {pg_r[PGI_W-1:0], rec_r.foff[PB_W-1:1]};

    alu_req.a   = off_r;
    alu_req.b   = ALU_W'(obj_r);
    alu_req.lim = lim_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt     = in_data.mode;
          size_nxt     = in_data.size;
          addr_nxt     = in_data.address;
          res_addr_nxt = '0;
          res_st_nxt   = ST_OK;
          state_nxt    = S_DECODE;
        end
      end

      S_DECODE: begin
        cls_nxt = size_class(size_r);
        case (mode_r)
          MODE_ALLOC_OBJ: begin
            state_nxt = S_CLASS;
          end
          MODE_FREE_OBJ: begin
            pg_nxt = addr_pg;
            rec_ra = addr_pg[PGI_W-1:0];
            state_nxt = addr_pg_ok ? S_FREE_UPD : S_DONE;
          end
          MODE_ALLOC_PG: begin
            if (page_avail) begin
              state_nxt = S_FPOP;
            end else begin
              res_st_nxt = ST_NO_PAGE;
              state_nxt  = S_DONE;
            end
          end
          default: begin
            // Page free: push onto the free stack unless the page is out of range or the stack is already full.
            if (addr_pg_ok && (count_r < NO_PAGE)) begin
              flink_we  = 1'b1;
              top_nxt   = addr_pg;
              count_nxt = count_r + PG_W'(1);
            end
            state_nxt = S_DONE;
          end
        endcase
      end

      S_CLASS: begin
        if (cls_r >= CLS_W'(NUM_CLASSES)) begin
          res_st_nxt = ST_NO_CLASS;
          state_nxt  = S_DONE;
        end else begin
          obj_nxt = CLASS_BYTES[cls_r];
          lim_nxt = ALU_W'(PAGE_BYTES) - ALU_W'(CLASS_BYTES[cls_r]);
          if (partial_head_r[cls_r] < NO_PAGE) begin
            pg_nxt    = partial_head_r[cls_r];
            rec_ra    = partial_head_r[cls_r][PGI_W-1:0];
            state_nxt = S_REC_WAIT;
          end else if (page_avail) begin
            state_nxt = S_FPOP;
          end else begin
            res_st_nxt = ST_NO_PAGE;
            state_nxt  = S_DONE;
          end
        end
      end

      S_FPOP: begin
        // Pop the top of the free page stack.
        top_nxt   = flink_val;
        count_nxt = count_r - PG_W'(1);
        if (mode_r == MODE_ALLOC_PG) begin
          res_addr_nxt = pg_base[ADDR_W-1:0];
          state_nxt    = S_DONE;
        end else begin
          pg_nxt    = top_r;
          off_nxt   = ALU_W'(obj_r);
          state_nxt = S_SEEK;
        end
      end

      S_SEEK: begin
        // Step up by the object size until past the header.
        alu_req.lim = ALU_W'(HEADER_BYTES);
        if (alu_rsp.a_ge) begin
          partial_head_nxt[cls_r] = pg_r;
          rec_nxt   = '{cls: cls_r, foff: off_r[PB_W-1:0], prev: NO_PAGE, next: NO_PAGE};
          state_nxt = S_THREAD;
        end else begin
          off_nxt = alu_rsp.sum;
        end
      end

      S_THREAD: begin
        // Link one object per cycle; the last object gets a null link.
        link_we = 1'b1;
        if (alu_rsp.sum_le) begin
          link_wd = alu_rsp.sum[PB_W-1:0];
          off_nxt = alu_rsp.sum;
        end else begin
          state_nxt = S_OBJ_RD;
        end
      end

      S_REC_WAIT: begin
        rec_nxt   = rec_q_r;
        state_nxt = S_OBJ_RD;
      end

      S_OBJ_RD: begin
        off_nxt   = ALU_W'(rec_r.foff);
        state_nxt = S_OBJ_UPD;
      end

      S_OBJ_UPD: begin
        // Pop the first free object; a page left with none moves to the full list.
        res_addr_nxt = obj_full[ADDR_W-1:0];
        rec_we       = 1'b1;
        rec_wd       = rec_r;
        rec_wd.foff  = link_rd;
        if (link_rd != '0) begin
          state_nxt = S_DONE;
        end else begin
          partial_head_nxt[cls_r] = rec_r.next;
          hd_nxt       = full_head_r[cls_r];
          fix_tgt_nxt  = rec_r.next;
          fix_val_nxt  = NO_PAGE;
          fix_next_nxt = 1'b0;
          ret_nxt      = S_FULL_B;
          state_nxt    = S_FX_RD;
        end
      end

      S_FULL_B: begin
        fix_tgt_nxt  = pg_r;
        fix_val_nxt  = hd_r;
        fix_next_nxt = 1'b1;
        ret_nxt      = S_FULL_C;
        state_nxt    = S_FX_RD;
      end

      S_FULL_C: begin
        fix_tgt_nxt  = hd_r;
        fix_val_nxt  = pg_r;
        fix_next_nxt = 1'b0;
        ret_nxt      = S_FULL_D;
        state_nxt    = S_FX_RD;
      end

      S_FULL_D: begin
        full_head_nxt[cls_r] = pg_r;
        state_nxt = S_DONE;
      end

      S_FREE_UPD: begin
        // Push the object onto its page; a page that had none unlinks from its list.
        cls_nxt      = rq_cls;
        link_we      = 1'b1;
        link_wa      = {pg_r[PGI_W-1:0], addr_off[PB_W-1:1]};
        link_wd      = rec_q_r.foff;
        rec_we       = 1'b1;
        rec_wd       = rec_q_r;
        rec_wd.foff  = addr_off;
        rec_nxt      = rec_q_r;
        rec_nxt.foff = addr_off;
        if (rec_q_r.foff != '0) begin
          state_nxt = S_DONE;
        end else begin
          nb_p_nxt     = rec_q_r.prev;
          nb_n_nxt     = rec_q_r.next;
          fix_tgt_nxt  = rec_q_r.prev;
          fix_val_nxt  = rec_q_r.next;
          fix_next_nxt = 1'b1;
          ret_nxt      = S_FREE_B;
          state_nxt    = S_FX_RD;
        end
      end

      S_FREE_B: begin
        fix_tgt_nxt  = nb_n_r;
        fix_val_nxt  = nb_p_r;
        fix_next_nxt = 1'b0;
        ret_nxt      = S_FREE_C;
        state_nxt    = S_FX_RD;
      end

      S_FREE_C: begin
        if (full_head_r[cls_r] == pg_r) begin
          full_head_nxt[cls_r] = nb_n_r;
        end
        hd_nxt       = partial_head_r[cls_r];
        fix_tgt_nxt  = partial_head_r[cls_r];
        fix_val_nxt  = pg_r;
        fix_next_nxt = 1'b0;
        ret_nxt      = S_FREE_D;
        state_nxt    = S_FX_RD;
      end

      S_FREE_D: begin
        // Class and free offset are untouched by neighbor updates.
        rec_we  = 1'b1;
        rec_wd  = '{cls: rec_r.cls, foff: rec_r.foff, prev: NO_PAGE, next: hd_r};
        partial_head_nxt[cls_r] = pg_r;
        state_nxt = S_DONE;
      end

      S_FX_RD: begin
        // Read the neighbor record, if there is a neighbor.
        rec_ra = fix_tgt_r[PGI_W-1:0];
        state_nxt = (fix_tgt_r < NO_PAGE) ? S_FX_WR : ret_r;
      end

      S_FX_WR: begin
        rec_we    = 1'b1;
        rec_wa    = fix_tgt_r[PGI_W-1:0];
        rec_wd    = rec_fix;
        state_nxt = ret_r;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.address_out  = res_addr_r;
          out_data_nxt.status       = res_st_r;
          out_data_nxt.pages_in_use = piu_full[PIU_W-1:0];
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      top_r       <= '0;
      count_r     <= NO_PAGE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        partial_head_r[i] <= NO_PAGE;
        full_head_r[i]    <= NO_PAGE;
      end
    end else begin
      state_r        <= state_nxt;
      ret_r          <= ret_nxt;
      top_r          <= top_nxt;
      count_r        <= count_nxt;
      out_valid_r    <= out_valid_nxt;
      partial_head_r <= partial_head_nxt;
      full_head_r    <= full_head_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    cls_r      <= cls_nxt;
    obj_r      <= obj_nxt;
    lim_r      <= lim_nxt;
    off_r      <= off_nxt;
    pg_r       <= pg_nxt;
    rec_r      <= rec_nxt;
    nb_p_r     <= nb_p_nxt;
    nb_n_r     <= nb_n_nxt;
    hd_r       <= hd_nxt;
    fix_tgt_r  <= fix_tgt_nxt;
    fix_val_r  <= fix_val_nxt;
    fix_next_r <= fix_next_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  // Page record memory.
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    rec_q_r <= rec_mem[rec_ra];
  end

  // Free page link memory with its written marks.
  always_ff @(posedge clk) begin
    if (flink_we) begin
      flink_mem[flink_wa] <= flink_wd;
    end
    flink_q_r     <= flink_mem[flink_ra];
    flink_vld_q_r <= flink_vld_r[flink_ra];
    flink_idx_q_r <= flink_ra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        flink_vld_r[i] <= 1'b0;
      end
    end else if (flink_we) begin
      flink_vld_r[flink_wa] <= 1'b1;
    end
  end

  // The page count moves by at most one per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((count_r == $past(count_r)) ||
                      (count_r == $past(count_r) + PG_W'(1)) ||
                      (count_r == $past(count_r) - PG_W'(1))))
    else $error("free page count jumped");

  // A no-free-page status is only reported when the stack is really empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (res_st_r == ST_NO_PAGE)) |-> !page_avail)
    else $error("no-page status with a page available");

  // An accepted transfer always starts decoding in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_DECODE))
    else $error("accepted transfer not decoded");

  // Threading only ever happens on a page inside the pool.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_THREAD) |-> (pg_r < NO_PAGE))
    else $error("threading outside the pool");

endmodule

`default_nettype wire

FILE: hdl/soa_alu.sv
// Shared add/compare unit of the slab object allocator sequencer.
// Depends on soa_pkg for the request and response types.
`default_nettype none

module soa_alu (
  input  soa_pkg::alu_req_t req,
  output soa_pkg::alu_rsp_t rsp
);
  import soa_pkg::*;

  logic [ALU_W-1:0] sum;

  // One add, then the two limit compares used for seeking and threading.
  assign sum        = req.a + req.b;
  assign rsp.sum    = sum;
  assign rsp.sum_le = (sum <= req.lim);
  assign rsp.a_ge   = (req.a >= req.lim);

endmodule

`default_nettype wire

FILE: hdl/soa_link_mem.sv
// Object link memory: one write port and one registered read port.
// Depends on soa_pkg only for the default sizes.
`default_nettype none

module soa_link_mem #(
  parameter int DEPTH = soa_pkg::NUM_PAGES_DEF * soa_pkg::PAGE_BYTES_DEF / 2,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = $clog2(soa_pkg::PAGE_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);
  import soa_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for slab_object_allocator_top: directed and random requests.
// Depends on soa_pkg and the allocator RTL; expected results come from a built-in predictor.
`timescale 1ns / 1ps

module tb;
  import soa_pkg::*;

  localparam int NPG     = 16;
  localparam int PGB     = 4096;
  localparam int HDR     = 24;
  localparam int NO_PG   = NPG;
  localparam int LDEPTH  = (NPG * PGB) / 2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  slab_object_allocator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state of the allocator.
  int pg_stack_link [NPG];
  int pg_stack_top;
  int pg_free_cnt;
  int slab_cls [NPG];
  int slab_free_off [NPG];
  int slab_prev [NPG];
  int slab_next [NPG];
  int partial_list [NUM_CLASSES];
  int full_list [NUM_CLASSES];
  int obj_link [LDEPTH];
  bit slab_used [NPG];

  // Stimulus and expected results, both in transfer order.
  in_item_t  req_queue [$];
  out_item_t expected_results [$];
  int        live_objects [$];
  bit        failed;
  int        results_seen;

  function automatic int link_idx(int pg, int off);
    return ((pg * PGB + off) >> 1) % LDEPTH;
  endfunction

  function automatic int pop_page();
    int pg;
    pg = pg_stack_top;
    if (pg_free_cnt == 0 || pg >= NPG) return NO_PG;
    pg_stack_top = pg_stack_link[pg];
    pg_free_cnt--;
    return pg;
  endfunction

  function automatic void set_prev(int pg, int v);
    if (pg < NPG) slab_prev[pg] = v;
  endfunction

  function automatic void set_next(int pg, int v);
    if (pg < NPG) slab_next[pg] = v;
  endfunction

  // Computes the result of one request and advances the predictor state.
  function automatic out_item_t predict_alloc_result(in_item_t it);
    out_item_t r;
    int c, obj, pg, off, first, oldoff;
    r = '0;
    r.status = ST_OK;
    if (it.mode == MODE_ALLOC_OBJ) begin
      c = NUM_CLASSES;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
        if (int'(it.size) <= int'(CLASS_BYTES[i])) c = i;
      end
      if (c >= NUM_CLASSES) begin
        r.status = ST_NO_CLASS;
      end else begin
        obj = int'(CLASS_BYTES[c]);
        pg = partial_list[c];
        if (pg >= NPG) begin
          pg = pop_page();
          if (pg < NPG) begin
            slab_cls[pg] = c;
            slab_prev[pg] = NO_PG;
            slab_next[pg] = NO_PG;
            first = ((HDR + obj - 1) / obj) * obj;
            slab_free_off[pg] = first;
            for (off = first; off + 2 * obj <= PGB; off += obj)
              obj_link[link_idx(pg, off)] = off + obj;
            obj_link[link_idx(pg, off)] = 0;
            partial_list[c] = pg;
            slab_used[pg] = 1'b1;
          end
        end
        if (pg >= NPG) begin
          r.status = ST_NO_PAGE;
        end else begin
          off = slab_free_off[pg];
          slab_free_off[pg] = obj_link[link_idx(pg, off)];
          if (slab_free_off[pg] == 0) begin
            // Last free object taken: the page moves to the full list.
            partial_list[c] = slab_next[pg];
            set_prev(partial_list[c], NO_PG);
            slab_next[pg] = full_list[c];
            set_prev(full_list[c], pg);
            full_list[c] = pg;
          end
          r.address_out = 16'(pg * PGB + off);
        end
      end
    end else if (it.mode == MODE_FREE_OBJ) begin
      pg = int'(it.address) / PGB;
      off = int'(it.address) % PGB;
      if (pg < NPG) begin
        c = slab_cls[pg];
        if (c >= NUM_CLASSES) c = 0;
        oldoff = slab_free_off[pg];
        obj_link[link_idx(pg, off)] = oldoff & 16'hffff;
        slab_free_off[pg] = off;
        if (oldoff == 0) begin
          // A full page gets a free object back and returns to the partial list.
          set_next(slab_prev[pg], slab_next[pg]);
          set_prev(slab_next[pg], slab_prev[pg]);
          if (full_list[c] == pg) full_list[c] = slab_next[pg];
          set_prev(partial_list[c], pg);
          slab_prev[pg] = NO_PG;
          slab_next[pg] = partial_list[c];
          partial_list[c] = pg;
        end
      end
    end else if (it.mode == MODE_ALLOC_PG) begin
      pg = pop_page();
      if (pg >= NPG) r.status = ST_NO_PAGE;
      else r.address_out = 16'(pg * PGB);
    end else begin
      pg = int'(it.address) / PGB;
      if (pg < NPG && pg_free_cnt < NPG) begin
        pg_stack_link[pg] = pg_stack_top;
        pg_stack_top = pg;
        pg_free_cnt++;
      end
    end
    r.pages_in_use = 5'(NPG - pg_free_cnt);
    return r;
  endfunction

  // Queues one request with its expected result and tracks live objects.
  task automatic add_req(logic [1:0] mode, logic [15:0] size, logic [15:0] addr);
    in_item_t  it;
    out_item_t r;
    it.mode = mode;
    it.size = size;
    it.address = addr;
    r = predict_alloc_result(it);
    if (mode == MODE_ALLOC_OBJ && r.status == ST_OK) live_objects.push_back(r.address_out);
    req_queue.push_back(it);
    expected_results.push_back(r);
  endtask

  // Frees a live object, or allocates a small object when none is live.
  task automatic free_live();
    int k;
    int a;
    if (live_objects.size() == 0) begin
      add_req(MODE_ALLOC_OBJ, 16'($urandom_range(3, 64)), 16'($urandom));
    end else begin
      k = $urandom_range(0, live_objects.size() - 1);
      a = live_objects[k];
      live_objects.delete(k);
      add_req(MODE_FREE_OBJ, 16'($urandom), 16'(a));
    end
  endtask

  function automatic logic [15:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(0, 2));
    if (r < 55) return 16'($urandom_range(3, 64));
    return 16'($urandom_range(65, 2048));
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stimulus: directed requests, then random traffic, then a page free sweep.
  initial begin
    int r, pg, a0;
    failed = 1'b0;
    for (int i = 0; i < NPG; i++) begin
      pg_stack_link[i] = i + 1;
      slab_used[i] = 1'b0;
    end
    pg_stack_top = 0;
    pg_free_cnt = NPG;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      partial_list[i] = NO_PG;
      full_list[i] = NO_PG;
    end

    // Smallest class, sizes beyond the largest class, and a page that fills at once.
    add_req(MODE_ALLOC_OBJ, 16'd0, 16'hffff);
    add_req(MODE_ALLOC_OBJ, 16'd2049, 16'd0);
    add_req(MODE_ALLOC_OBJ, 16'hffff, 16'd0);
    add_req(MODE_ALLOC_OBJ, 16'd2048, 16'd0);
    a0 = live_objects[$];
    add_req(MODE_ALLOC_OBJ, 16'd2048, 16'd0);
    add_req(MODE_FREE_OBJ, 16'hffff, 16'(a0));
    add_req(MODE_ALLOC_OBJ, 16'd12, 16'd0);
    a0 = live_objects[$];
    add_req(MODE_ALLOC_OBJ, 16'd13, 16'd0);
    add_req(MODE_FREE_OBJ, 16'd0, 16'(a0));
    // Odd address inside the 2-byte class slab.
    add_req(MODE_FREE_OBJ, 16'd0, 16'd25);
    // Drain the page stack, then run into the empty pool.
    for (int i = 0; i < 11; i++) add_req(MODE_ALLOC_PG, 16'($urandom), 16'($urandom));
    add_req(MODE_ALLOC_PG, 16'd0, 16'd0);
    add_req(MODE_ALLOC_OBJ, 16'd300, 16'd0);
    add_req(MODE_ALLOC_OBJ, 16'd2, 16'd0);
    // Unaligned page free.
    add_req(MODE_FREE_PG, 16'd0, 16'h1abc);

    for (int n = 0; n < 250; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_req(MODE_ALLOC_OBJ, rand_size(), 16'($urandom));
      end else if (r < 80) begin
        free_live();
      end else if (r < 85) begin
        pg = $urandom_range(0, NPG - 1);
        if (slab_used[pg]) add_req(MODE_FREE_OBJ, 16'($urandom),
                                   16'(pg * PGB + $urandom_range(0, PGB - 1)));
        else free_live();
      end else if (r < 92) begin
        add_req(MODE_ALLOC_PG, 16'($urandom), 16'($urandom));
      end else begin
        add_req(MODE_FREE_PG, 16'($urandom), 16'($urandom));
      end
    end

    // Return every page, then one more free on a full stack.
    for (int i = 0; i < NPG; i++)
      add_req(MODE_FREE_PG, 16'($urandom), 16'(i * PGB + $urandom_range(0, PGB - 1)));
    add_req(MODE_FREE_PG, 16'($urandom), 16'($urandom));

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every result to come back.
    while (req_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && !out_valid) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Request driver with random gaps, sometimes running back to back.
  int  send_gap;
  bit  send_burst;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
      send_burst <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if ($urandom_range(0, 49) == 0) send_burst <= ~send_burst;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= req_queue.pop_front();
        if (send_burst || $urandom_range(0, 9) < 6) send_gap <= 0;
        else if ($urandom_range(0, 9) == 0) send_gap <= $urandom_range(20, 60);
        else send_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and checker; the receiver stalls at random and holds off once at length.
  int hold_cnt;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          failed <= 1'b1;
        end else begin
          if (out_data.address_out !== expected_results[0].address_out ||
              out_data.status !== expected_results[0].status ||
              out_data.pages_in_use !== expected_results[0].pages_in_use) begin
            $display("%0t: mismatch expected addr %h st %0d piu %0d, got addr %h st %0d piu %0d",
                     $time, expected_results[0].address_out, expected_results[0].status,
                     expected_results[0].pages_in_use, out_data.address_out,
                     out_data.status, out_data.pages_in_use);
            failed <= 1'b1;
          end
          void'(expected_results.pop_front());
        end
      end
      // One long hold-off after some traffic, so that the input backs up.
      if (!hold_done && results_seen == 40) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= (hold_cnt > 1);
      end else if ($urandom_range(0, 99) < 3) begin
        hold_cnt <= $urandom_range(10, 40);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  // Run limit.
  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
